/* rtl/core/opfa_pkg.sv */
`timescale 1ns / 1ps

package opfa_pkg;

  // Fixed-point layout
  localparam int ANGLE_FRAC_BITS = 16;
  localparam int QF              = 30;                    // internal angle/trig fraction bits
  localparam int ITERS           = 30;                    // CORDIC iterations
  localparam int AW              = 24;                    // angle field width
  localparam int ANG_SHIFT       = QF - ANGLE_FRAC_BITS;  // Q.frac -> Q30
  localparam int VW              = AW + ANG_SHIFT + 2;    // widened angle plus pi
  localparam int TSH             = VW - 16;               // drop bits before reciprocal
  localparam int TW              = 16;                    // coarse value / quotient width
  localparam int MW              = 32;                    // reciprocal width
  localparam int TWOW            = 35;                    // width of the 2*pi constant
  localparam int RW              = 36;                    // remainder width
  localparam int ZW              = 34;                    // CORDIC angle width
  localparam int XW              = 34;                    // CORDIC vector width

  localparam longint PI_L      = 64'sd3373259426;
  localparam longint HALF_PI_L = 64'sd1686629713;
  localparam longint EPS_L     = 64'sd107374;
  localparam longint TWO_PI_L  = 2 * PI_L;
  localparam longint MAXP_L    = HALF_PI_L - EPS_L;
  localparam longint GAIN_L    = 64'sd652032874;
  localparam longint RECIP_L   = (64'sd1 <<< (TSH + 32)) / TWO_PI_L;

  typedef struct packed {
    logic signed [31:0] target_x;
    logic signed [31:0] target_y;
    logic signed [31:0] target_z;
    logic signed [23:0] pitch_angle;
    logic signed [23:0] yaw_angle;
    logic signed [31:0] orbit_radius;
  } in_req_t;

  typedef struct packed {
    logic signed [31:0] orbit_x;
    logic signed [31:0] orbit_y;
    logic signed [31:0] orbit_z;
  } out_res_t;

  // Arctangent table, Q30, truncated toward zero
  function automatic logic [31:0] atan_q30(input int i);
    logic [31:0] a;
    unique case (i)
      0:  a = 32'd843314856;
      1:  a = 32'd497837829;
      2:  a = 32'd263043836;
      3:  a = 32'd133525158;
      4:  a = 32'd67021686;
      5:  a = 32'd33543515;
      6:  a = 32'd16775850;
      7:  a = 32'd8388437;
      8:  a = 32'd4194282;
      9:  a = 32'd2097149;
      10: a = 32'd1048575;
      11: a = 32'd524287;
      12: a = 32'd262143;
      13: a = 32'd131071;
      14: a = 32'd65535;
      15: a = 32'd32767;
      16: a = 32'd16383;
      17: a = 32'd8191;
      18: a = 32'd4095;
      19: a = 32'd2047;
      20: a = 32'd1023;
      21: a = 32'd511;
      22: a = 32'd255;
      23: a = 32'd127;
      24: a = 32'd63;
      25: a = 32'd31;
      26: a = 32'd15;
      27: a = 32'd7;
      28: a = 32'd3;
      29: a = 32'd1;
      default: a = 32'd0;
    endcase
    return a;
  endfunction

endpackage

/* rtl/core/opfa_cordic.sv */
`timescale 1ns / 1ps

module opfa_cordic import opfa_pkg::*; (
  input  logic                 clk,
  input  logic signed [ZW-1:0] angle,
  output logic signed [XW-1:0] cos_q,
  output logic signed [XW-1:0] sin_q
);

  logic signed [XW-1:0] x [0:ITERS];
  logic signed [XW-1:0] y [0:ITERS];
  logic signed [ZW-1:0] z [0:ITERS];

  assign x[0] = XW'(GAIN_L);
  assign y[0] = '0;
  assign z[0] = angle;

  // One rotation per stage; shift amounts are fixed per stage
  for (genvar i = 0; i < ITERS; i++) begin : g_stage
    localparam logic signed [ZW-1:0] ATAN = ZW'(atan_q30(i));
    always_ff @(posedge clk) begin
      if (!z[i][ZW-1]) begin
        x[i+1] <= x[i] - (y[i] >>> i);
        y[i+1] <= y[i] + (x[i] >>> i);
        z[i+1] <= z[i] - ATAN;
      end else begin
        x[i+1] <= x[i] + (y[i] >>> i);
        y[i+1] <= y[i] - (x[i] >>> i);
        z[i+1] <= z[i] + ATAN;
      end
    end
  end

  assign cos_q = x[ITERS];
  assign sin_q = y[ITERS];

endmodule

/* rtl/core/orbit_position_from_angles.sv */
`timescale 1ns / 1ps

// Channel   Ports                      Dir  Handshake
// request   start, busy, req           in   taken when start=1 and busy=0
// result    done, result               out  done pulses one cycle, no backpressure
//
// Fully pipelined: one request per cycle, busy is held low.
// Pipeline from accept to done: five stages of request capture, pitch clamp and
// yaw wrap, thirty CORDIC rotation stages, four multiply/round/add stages.
// Synchronous active-high reset clears the valid bits only; data registers
// are not reset. The receiver cannot stall, so the pipeline never holds.

module orbit_position_from_angles import opfa_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  input  in_req_t  req,
  output logic     done,
  output out_res_t result
);

  typedef struct packed {
    logic signed [31:0] tx;
    logic signed [31:0] ty;
    logic signed [31:0] tz;
    logic signed [31:0] r;
    logic               flip;
  } side_t;

  localparam int PRW = TW + TWOW + 1;
  localparam int MPW = 32 + XW;        // radius times trig
  localparam int RCW = XW + 2;         // rounded radius product
  localparam int MQW = RCW + XW;       // second product

  localparam logic signed [VW-1:0]   PI_V    = VW'(PI_L);
  localparam logic signed [VW-1:0]   MAXP_V  = VW'(MAXP_L);
  localparam logic signed [MW-1:0]   RECIP_V = MW'(RECIP_L);
  localparam logic signed [TWOW-1:0] TWO_V   = TWOW'(TWO_PI_L);
  localparam logic signed [RW-1:0]   TWO_R   = RW'(TWO_PI_L);
  localparam logic signed [RW-1:0]   PI_R    = RW'(PI_L);
  localparam logic signed [RW-1:0]   HALF_R  = RW'(HALF_PI_L);

  function automatic logic signed [31:0] sat32(input logic signed [MQW-1:0] v);
    logic signed [31:0] s;
    if (v > MQW'(64'sd2147483647))       s = 32'sh7fffffff;
    else if (v < MQW'(-64'sd2147483648)) s = 32'sh80000000;
    else                                 s = v[31:0];
    return s;
  endfunction

  assign busy = 1'b0;

  // Stage 1: capture request
  in_req_t s1;
  logic    s1_vld;
  always_ff @(posedge clk) begin
    s1 <= req;
    if (rst) s1_vld <= 1'b0;
    else     s1_vld <= start & ~busy;
  end

  // Stage 2: clamp pitch, offset yaw by pi, estimate quotient by 2*pi
  logic signed [VW-1:0]      p_wide, p_clamp, yv_c;
  logic signed [TW-1:0]      tdiv;
  logic signed [TW+MW-1:0]   tprod;
  always_comb begin
    p_wide = VW'(s1.pitch_angle) <<< ANG_SHIFT;
    priority if (p_wide > MAXP_V)  p_clamp = MAXP_V;
    else if (p_wide < -MAXP_V)     p_clamp = -MAXP_V;
    else                           p_clamp = p_wide;
    yv_c  = (VW'(s1.yaw_angle) <<< ANG_SHIFT) + PI_V;
    tdiv  = TW'(yv_c >>> TSH);
    tprod = (TW+MW)'(tdiv) * (TW+MW)'(RECIP_V);
  end

  logic signed [ZW-1:0] s2_p;
  logic signed [VW-1:0] s2_yv;
  logic signed [TW-1:0] s2_q;
  side_t                s2_side;
  logic                 s2_vld;
  always_ff @(posedge clk) begin
    s2_p    <= ZW'(p_clamp);
    s2_yv   <= yv_c;
    s2_q    <= TW'(tprod >>> 32);
    s2_side <= '{tx: s1.target_x, ty: s1.target_y, tz: s1.target_z,
                 r: s1.orbit_radius, flip: 1'b0};
    if (rst) s2_vld <= 1'b0;
    else     s2_vld <= s1_vld;
  end

  // Stage 3: raw remainder, off by at most one period
  logic signed [PRW-1:0] qmul;
  logic signed [PRW-1:0] rem_wide;
  always_comb begin
    qmul     = PRW'(s2_q) * PRW'(TWO_V);
    rem_wide = PRW'(s2_yv) - qmul;
  end

  logic signed [ZW-1:0] s3_p;
  logic signed [RW-1:0] s3_rem;
  side_t                s3_side;
  logic                 s3_vld;
  always_ff @(posedge clk) begin
    s3_p    <= s2_p;
    s3_rem  <= RW'(rem_wide);
    s3_side <= s2_side;
    if (rst) s3_vld <= 1'b0;
    else     s3_vld <= s2_vld;
  end

  // Stage 4: correct remainder into [0, 2*pi)
  logic signed [RW-1:0] rem_c;
  always_comb begin
    priority if (s3_rem < 0)     rem_c = s3_rem + TWO_R;
    else if (s3_rem >= TWO_R)    rem_c = s3_rem - TWO_R;
    else                         rem_c = s3_rem;
  end

  logic signed [ZW-1:0] s4_p;
  logic signed [RW-1:0] s4_rem;
  side_t                s4_side;
  logic                 s4_vld;
  always_ff @(posedge clk) begin
    s4_p    <= s3_p;
    s4_rem  <= rem_c;
    s4_side <= s3_side;
    if (rst) s4_vld <= 1'b0;
    else     s4_vld <= s3_vld;
  end

  // Stage 5: back to [-pi, pi), then fold into [-pi/2, pi/2] with a flip
  logic signed [RW-1:0] yw_c, yf_c;
  logic                 flip_c;
  always_comb begin
    yw_c = s4_rem - PI_R;
    priority if (yw_c > HALF_R) begin
      yf_c   = yw_c - PI_R;
      flip_c = 1'b1;
    end else if (yw_c < -HALF_R) begin
      yf_c   = yw_c + PI_R;
      flip_c = 1'b1;
    end else begin
      yf_c   = yw_c;
      flip_c = 1'b0;
    end
  end

  logic signed [ZW-1:0] s5_p, s5_y;
  side_t                side_q [0:ITERS];
  logic                 vld_q  [0:ITERS];
  always_ff @(posedge clk) begin
    s5_p      <= s4_p;
    s5_y      <= ZW'(yf_c);
    side_q[0] <= '{tx: s4_side.tx, ty: s4_side.ty, tz: s4_side.tz,
                   r: s4_side.r, flip: flip_c};
    if (rst) vld_q[0] <= 1'b0;
    else     vld_q[0] <= s4_vld;
  end

  // CORDIC pipelines, sideband travels alongside
  logic signed [XW-1:0] cp, sp, cy, sy;
  opfa_cordic u_cordic_pitch (.clk(clk), .angle(s5_p), .cos_q(cp), .sin_q(sp));
  opfa_cordic u_cordic_yaw   (.clk(clk), .angle(s5_y), .cos_q(cy), .sin_q(sy));

  for (genvar i = 0; i < ITERS; i++) begin : g_side
    always_ff @(posedge clk) begin
      side_q[i+1] <= side_q[i];
      if (rst) vld_q[i+1] <= 1'b0;
      else     vld_q[i+1] <= vld_q[i];
    end
  end

  // M1: radius products, apply yaw flip
  localparam logic signed [MPW-1:0] HALF_M = MPW'(64'sd1 <<< (QF - 1));
  localparam logic signed [MQW-1:0] HALF_Q = MQW'(64'sd1 <<< (QF - 1));

  logic signed [MPW-1:0] m1_rc, m1_rs;
  logic signed [XW-1:0]  m1_cy, m1_sy;
  side_t                 m1_side;
  logic                  m1_vld;
  always_ff @(posedge clk) begin
    m1_rc   <= MPW'(side_q[ITERS].r) * MPW'(cp);
    m1_rs   <= MPW'(side_q[ITERS].r) * MPW'(sp);
    m1_cy   <= side_q[ITERS].flip ? -cy : cy;
    m1_sy   <= side_q[ITERS].flip ? -sy : sy;
    m1_side <= side_q[ITERS];
    if (rst) m1_vld <= 1'b0;
    else     m1_vld <= vld_q[ITERS];
  end

  // M2: round half up
  logic signed [MPW-1:0] rc_rnd, rs_rnd;
  assign rc_rnd = (m1_rc + HALF_M) >>> QF;
  assign rs_rnd = (m1_rs + HALF_M) >>> QF;

  logic signed [RCW-1:0] m2_rcp, m2_rsp;
  logic signed [XW-1:0]  m2_cy, m2_sy;
  side_t                 m2_side;
  logic                  m2_vld;
  always_ff @(posedge clk) begin
    m2_rcp  <= RCW'(rc_rnd);
    m2_rsp  <= RCW'(rs_rnd);
    m2_cy   <= m1_cy;
    m2_sy   <= m1_sy;
    m2_side <= m1_side;
    if (rst) m2_vld <= 1'b0;
    else     m2_vld <= m1_vld;
  end

  // M3: second products, y sum
  logic signed [MQW-1:0] m3_px, m3_pz, m3_y;
  side_t                 m3_side;
  logic                  m3_vld;
  always_ff @(posedge clk) begin
    m3_px   <= MQW'(m2_rcp) * MQW'(m2_sy);
    m3_pz   <= MQW'(m2_rcp) * MQW'(m2_cy);
    m3_y    <= MQW'(m2_side.ty) - MQW'(m2_rsp);
    m3_side <= m2_side;
    if (rst) m3_vld <= 1'b0;
    else     m3_vld <= m2_vld;
  end

  // M4: round, add target, saturate
  logic signed [MQW-1:0] sum_x, sum_z;
  assign sum_x = MQW'(m3_side.tx) + ((m3_px + HALF_Q) >>> QF);
  assign sum_z = MQW'(m3_side.tz) + ((m3_pz + HALF_Q) >>> QF);

  always_ff @(posedge clk) begin
    result.orbit_x <= sat32(sum_x);
    result.orbit_y <= sat32(m3_y);
    result.orbit_z <= sat32(sum_z);
    if (rst) done <= 1'b0;
    else     done <= m3_vld;
  end

  // Checks
  a_pitch_bound: assert property (@(posedge clk) disable iff (rst)
    s2_vld |-> (s2_p <= ZW'(MAXP_L)) && (s2_p >= -ZW'(MAXP_L)))
    else $error("pitch outside clamp bound");

  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    s4_vld |-> (s4_rem >= 0) && (s4_rem < TWO_R))
    else $error("yaw remainder not reduced");

  a_yaw_fold: assert property (@(posedge clk) disable iff (rst)
    vld_q[0] |-> (s5_y <= ZW'(HALF_PI_L)) && (s5_y >= -ZW'(HALF_PI_L)))
    else $error("folded yaw outside half circle");

endmodule

/* sim/orbit_position_from_angles_tb.sv */
`timescale 1ns / 1ps

module orbit_position_from_angles_tb;
  import opfa_pkg::*;

  localparam longint PI_Q       = 64'sd3373259426;
  localparam longint HALF_PI_Q  = 64'sd1686629713;
  localparam longint PITCH_LIM  = HALF_PI_Q - 64'sd107374;
  localparam longint GAIN_INV_Q = 64'sd652032874;
  localparam int     LATENCY    = 39;

  logic     clk;
  logic     rst;
  logic     start;
  logic     busy;
  in_req_t  req;
  logic     done;
  out_res_t result;

  in_req_t  pending_reqs[$];
  out_res_t expected_positions[$];
  int       mismatch_count;
  bit       stimulus_done;

  longint arctan_q30[30] = '{
    843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
    16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
    131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255,
    127, 63, 31, 15, 7, 3, 1};

  orbit_position_from_angles DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .req(req), .done(done), .result(result)
  );

  always #10 clk = ~clk;

  // Round-half-up Q30 product; >>> on longint floors like an arithmetic shift.
  function automatic longint round_q30(longint a, longint b);
    return (a * b + (64'sd1 <<< 29)) >>> 30;
  endfunction

  function automatic logic signed [31:0] clip32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // Rotation-mode CORDIC, angle in Q30 within +-pi/2.
  task automatic rotate_unit(input longint angle, output longint c, output longint s);
    longint vx, vy, vz, dx, dy;
    vx = GAIN_INV_Q;
    vy = 0;
    vz = angle;
    for (int i = 0; i < 30; i++) begin
      dx = vy >>> i;
      dy = vx >>> i;
      if (vz >= 0) begin
        vx -= dx; vy += dy; vz -= arctan_q30[i];
      end else begin
        vx += dx; vy -= dy; vz += arctan_q30[i];
      end
    end
    c = vx;
    s = vy;
  endtask

  task automatic predict_orbit(input in_req_t r, output out_res_t o);
    longint p, yw, rem, cp, sp, cy, sy, rcp, rad;
    bit flip;
    p   = longint'(r.pitch_angle) * 64'sd16384;
    yw  = longint'(r.yaw_angle) * 64'sd16384;
    rad = longint'(r.orbit_radius);
    flip = 0;
    // Clamp pitch just short of the poles.
    if (p > PITCH_LIM) p = PITCH_LIM;
    if (p < -PITCH_LIM) p = -PITCH_LIM;
    // Wrap yaw into [-pi, pi), then fold into the CORDIC range.
    rem = (yw + PI_Q) % (2 * PI_Q);
    if (rem < 0) rem += 2 * PI_Q;
    yw = rem - PI_Q;
    if (yw > HALF_PI_Q) begin
      yw -= PI_Q; flip = 1;
    end else if (yw < -HALF_PI_Q) begin
      yw += PI_Q; flip = 1;
    end
    rotate_unit(p, cp, sp);
    rotate_unit(yw, cy, sy);
    if (flip) begin
      cy = -cy; sy = -sy;
    end
    rcp = round_q30(rad, cp);
    o.orbit_x = clip32(longint'(r.target_x) + round_q30(rcp, sy));
    o.orbit_y = clip32(longint'(r.target_y) - round_q30(rad, sp));
    o.orbit_z = clip32(longint'(r.target_z) + round_q30(rcp, cy));
  endtask

  function automatic logic [23:0] pick_angle();
    case ($urandom_range(0, 5))
      0: return 24'($urandom());
      1: return 24'($signed($urandom_range(0, 205887)) - 102943);  // about +-pi/2
      2: return 24'($signed($urandom_range(0, 411774)) - 205887);  // about +-pi
      3: return $urandom_range(0, 1) ? 24'h7fffff : 24'h800000;
      default: return 24'($signed($urandom_range(0, 1647096)) - 823548); // +-4 pi
    endcase
  endfunction

  function automatic logic [31:0] pick_pos();
    case ($urandom_range(0, 4))
      0: return $urandom();
      1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      default: return 32'($signed($urandom_range(0, 2097152)) - 1048576) <<< 8;
    endcase
  endfunction

  task automatic queue_request(input logic [31:0] tx, ty, tz, input logic [23:0] pa, ya,
                               input logic [31:0] rad);
    in_req_t r;
    r.target_x = tx; r.target_y = ty; r.target_z = tz;
    r.pitch_angle = pa; r.yaw_angle = ya; r.orbit_radius = rad;
    pending_reqs.push_back(r);
  endtask

  // Fill the request queue: directed corners first, then random requests.
  initial begin
    // Zero pose, poles, clamp boundaries and beyond.
    queue_request(0, 0, 0, 0, 0, 32'h00010000);
    queue_request(0, 0, 0, 24'd102943, 0, 32'h00010000);
    queue_request(0, 0, 0, -24'sd102943, 0, 32'h00010000);
    queue_request(0, 0, 0, 24'h7fffff, 24'h7fffff, 32'h7fffffff);
    queue_request(0, 0, 0, 24'h800000, 24'h800000, 32'h80000000);
    // Yaw folded by pi on both sides, and exactly at -pi and +pi.
    queue_request(32'h00100000, 0, 0, 0, 24'd150000, 32'h00050000);
    queue_request(0, 32'h00100000, 0, 0, -24'sd150000, 32'h00050000);
    queue_request(0, 0, 0, 0, -24'sd205887, 32'h00020000);
    queue_request(0, 0, 0, 0, 24'd205887, 32'h00020000);
    queue_request(0, 0, 0, 24'd30000, 24'd411775, 32'h00030000);
    // Saturation at both rails.
    queue_request(32'h7fffffff, 32'h80000000, 32'h7fffffff, -24'sd60000, 0,
                  32'h7fffffff);
    queue_request(32'h80000000, 32'h7fffffff, 32'h80000000, 24'd60000, 24'd205887,
                  32'h7fffffff);
    queue_request(32'hffffffff, 32'hffffffff, 32'hffffffff, 24'hffffff, 24'hffffff,
                  32'hffffffff);
    queue_request(32'h55555555, 32'haaaaaaaa, 32'h55555555, 24'h555555, 24'haaaaaa,
                  32'haaaaaaaa);
    queue_request(32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa, 24'haaaaaa, 24'h555555,
                  32'h55555555);
    for (int n = 0; n < 1550; n++)
      queue_request(pick_pos(), pick_pos(), pick_pos(), pick_angle(), pick_angle(),
                    pick_pos());
  end

  // Driver: hold start between gaps of random length, mostly short.
  int gap_left;
  always @(posedge clk) begin
    in_req_t r;
    out_res_t o;
    if (rst) begin
      start    <= 1'b0;
      gap_left <= 0;
    end else begin
      if (start && !busy) begin
        predict_orbit(req, o);
        expected_positions.push_back(o);
      end
      if (start && busy) begin
        // hold the current request
      end else if (gap_left > 0) begin
        start    <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_reqs.size() > 0) begin
        r = pending_reqs.pop_front();
        req   <= r;
        start <= 1'b1;
        case ($urandom_range(0, 9))
          0, 1:    gap_left <= $urandom_range(1, 3);
          2:       gap_left <= ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : 1;
          default: gap_left <= 0;
        endcase
      end else begin
        start <= 1'b0;
        stimulus_done <= 1'b1;
      end
    end
  end

  // Monitor: compare every strobed result with the oldest expectation.
  always @(posedge clk) begin
    out_res_t e;
    if (!rst && done) begin
      if (expected_positions.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result x=%0d y=%0d z=%0d",
                   result.orbit_x, result.orbit_y, result.orbit_z);
      end else begin
        e = expected_positions.pop_front();
        if (result !== e) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: expected x=%0d y=%0d z=%0d, got x=%0d y=%0d z=%0d",
                     e.orbit_x, e.orbit_y, e.orbit_z,
                     result.orbit_x, result.orbit_y, result.orbit_z);
        end
      end
    end
  end

  initial begin
    clk = 0;
    rst = 1;
    start = 0;
    req = '0;
    stimulus_done = 0;
    mismatch_count = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    wait (stimulus_done && expected_positions.size() == 0);
    repeat (LATENCY + 10) @(posedge clk);
    if (mismatch_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Drop the run if it hangs.
  initial begin
    #20000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
